### sv/abt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abt_pkg: shared definitions for the array-based binary tree store
// Table sizing, result codes, link format and the node table request/response.
// ----------------------------------------------------------------------------
package abt_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int FILL_W      = $clog2(TABLE_DEPTH + 1);
    localparam int OUT_IDX_W   = 6;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_NOT_FOUND = 2'd1,
        STATUS_FULL      = 2'd2
    } status_t;

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_QUERY  = 1'b1;

    // side[1] set means root, else side[0] picks left (0) or right (1)
    localparam logic SIDE_LEFT = 1'b0;

    typedef struct packed {
        logic             vld;
        logic [IDX_W-1:0] idx;
    } link_t;

    typedef struct packed {
        logic             val_we;
        logic [IDX_W-1:0] val_waddr;
        logic [7:0]       val_wdata;
        logic [IDX_W-1:0] val_raddr;
        logic             lft_we;
        logic [IDX_W-1:0] lft_waddr;
        link_t            lft_wdata;
        logic             rgt_we;
        logic [IDX_W-1:0] rgt_waddr;
        link_t            rgt_wdata;
        logic             par_we;
        logic [IDX_W-1:0] par_waddr;
        link_t            par_wdata;
        logic [IDX_W-1:0] lnk_raddr;
    } tbl_req_t;

    typedef struct packed {
        logic [7:0] val_rdata;
        link_t      lft_rdata;
        link_t      rgt_rdata;
        link_t      par_rdata;
    } tbl_rsp_t;

    // index as seen on the result port: low bits only
    function automatic logic [OUT_IDX_W-1:0] out_idx(input logic [IDX_W-1:0] idx);
        logic [IDX_W+OUT_IDX_W-1:0] tmp;
        tmp = {{OUT_IDX_W{1'b0}}, idx};
        return tmp[OUT_IDX_W-1:0];
    endfunction

endpackage

### sv/abt_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abt_req_if: request channel of the tree store
// Valid/ready channel carrying one insert or query command.
// ----------------------------------------------------------------------------
interface abt_req_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic [7:0] search_key;
    logic [7:0] new_value;
    logic [1:0] side;

    modport source (output valid, output mode, output search_key, output new_value,
                    output side, input ready);
    modport sink   (input valid, input mode, input search_key, input new_value,
                    input side, output ready);
endinterface

### sv/abt_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abt_rsp_if: result channel of the tree store
// Valid/ready channel carrying one result per command.
// ----------------------------------------------------------------------------
interface abt_rsp_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [5:0] node_index;
    logic [7:0] node_value;
    logic       parent_present;
    logic [5:0] parent_index;
    logic       left_present;
    logic [7:0] left_value;
    logic       right_present;
    logic [7:0] right_value;

    modport source (output valid, output status, output node_index, output node_value,
                    output parent_present, output parent_index, output left_present,
                    output left_value, output right_present, output right_value,
                    input ready);
    modport sink   (input valid, input status, input node_index, input node_value,
                    input parent_present, input parent_index, input left_present,
                    input left_value, input right_present, input right_value,
                    output ready);
endinterface

### sv/abt_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abt_table: node table memories
// Node values plus left, right and parent links, one write and one registered
// read per memory per cycle. The three link memories share a read address.
// ----------------------------------------------------------------------------
module abt_table (
    input  logic              clk,
    input  abt_pkg::tbl_req_t tq,
    output abt_pkg::tbl_rsp_t tr
);

    logic [7:0]     val_mem [abt_pkg::TABLE_DEPTH];
    abt_pkg::link_t lft_mem [abt_pkg::TABLE_DEPTH];
    abt_pkg::link_t rgt_mem [abt_pkg::TABLE_DEPTH];
    abt_pkg::link_t par_mem [abt_pkg::TABLE_DEPTH];

    logic [7:0]     val_rd_reg;
    abt_pkg::link_t lft_rd_reg;
    abt_pkg::link_t rgt_rd_reg;
    abt_pkg::link_t par_rd_reg;

    always_ff @(posedge clk)
    begin
        if (tq.val_we)
        begin
            val_mem[tq.val_waddr] <= tq.val_wdata;
        end
        val_rd_reg <= val_mem[tq.val_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (tq.lft_we)
        begin
            lft_mem[tq.lft_waddr] <= tq.lft_wdata;
        end
        lft_rd_reg <= lft_mem[tq.lnk_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (tq.rgt_we)
        begin
            rgt_mem[tq.rgt_waddr] <= tq.rgt_wdata;
        end
        rgt_rd_reg <= rgt_mem[tq.lnk_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (tq.par_we)
        begin
            par_mem[tq.par_waddr] <= tq.par_wdata;
        end
        par_rd_reg <= par_mem[tq.lnk_raddr];
    end

    assign tr.val_rdata = val_rd_reg;
    assign tr.lft_rdata = lft_rd_reg;
    assign tr.rgt_rdata = rgt_rd_reg;
    assign tr.par_rdata = par_rd_reg;

endmodule

### sv/array_binary_tree_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// array_binary_tree_store: binary tree kept in a fixed node table
// Insert appends a node (root or child of the first node matching a key);
// query finds the first node matching a key and reports its links.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one command per transfer (mode, search_key, new_value, side);
//   rsp returns exactly one result per command, in order.
//   req.ready is high only while the sequencer is idle: one command at a time.
//   The key search reads one table entry per cycle through a single read
//   port of the value memory, compared in the following cycle.
//   An insert into a full table goes straight to its result (status full);
//   an insert as root skips the key search; an insert as child and a query
//   first search for the key, and a miss ends with status not found. A query
//   hit then reads the node's links and the values of its children.
//   The result sits in an output register; the next command is accepted while
//   it waits. A stalled rsp holds the block in its final step until the
//   output register frees up.
//   Reset empties the table at once (fill count to zero); the memories need
//   no clearing since only entries below the fill count are read.
// ----------------------------------------------------------------------------
module array_binary_tree_store (
    input  logic       clk,
    input  logic       rst_n,
    abt_req_if.sink    req,
    abt_rsp_if.source  rsp
);

    typedef struct packed {
        logic [1:0] status;
        logic [5:0] node_index;
        logic [7:0] node_value;
        logic       parent_present;
        logic [5:0] parent_index;
        logic       left_present;
        logic [7:0] left_value;
        logic       right_present;
        logic [7:0] right_value;
    } res_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_INS_NODE,
        ST_INS_LINK,
        ST_Q_LINK,
        ST_Q_LEFT,
        ST_Q_RIGHT,
        ST_Q_END,
        ST_DONE
    } state_t;

    localparam logic [abt_pkg::FILL_W-1:0] FILL_FULL = abt_pkg::FILL_W'(abt_pkg::TABLE_DEPTH);

    state_t                       state_reg, state_next;
    logic                         mode_reg, mode_next;
    logic [7:0]                   key_reg, key_next;
    logic [7:0]                   value_reg, value_next;
    logic [1:0]                   side_reg, side_next;
    logic [abt_pkg::FILL_W-1:0]   fill_reg, fill_next;
    logic [abt_pkg::FILL_W-1:0]   scan_reg, scan_next;
    logic                         rd_pend_reg, rd_pend_next;
    logic [abt_pkg::IDX_W-1:0]    rd_idx_reg, rd_idx_next;
    logic [abt_pkg::IDX_W-1:0]    hit_reg, hit_next;
    abt_pkg::link_t               par_reg, par_next;
    abt_pkg::link_t               lft_reg, lft_next;
    abt_pkg::link_t               rgt_reg, rgt_next;
    logic [7:0]                   lval_reg, lval_next;
    res_t                         res_reg, res_next;
    res_t                         out_reg, out_next;
    logic                         out_valid_reg, out_valid_next;

    abt_pkg::tbl_req_t            tq;
    abt_pkg::tbl_rsp_t            tr;
    logic [abt_pkg::IDX_W-1:0]    slot;
    logic                         match;

    abt_table u_table (
        .clk (clk),
        .tq  (tq),
        .tr  (tr)
    );

    assign slot  = fill_reg[abt_pkg::IDX_W-1:0];
    assign match = rd_pend_reg && (tr.val_rdata == key_reg);

    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        key_next       = key_reg;
        value_next     = value_reg;
        side_next      = side_reg;
        fill_next      = fill_reg;
        scan_next      = scan_reg;
        rd_pend_next   = rd_pend_reg;
        rd_idx_next    = rd_idx_reg;
        hit_next       = hit_reg;
        par_next       = par_reg;
        lft_next       = lft_reg;
        rgt_next       = rgt_reg;
        lval_next      = lval_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        tq             = '0;

        if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    mode_next    = req.mode;
                    key_next     = req.search_key;
                    value_next   = req.new_value;
                    side_next    = req.side;
                    scan_next    = '0;
                    rd_pend_next = 1'b0;
                    if (req.mode == abt_pkg::MODE_INSERT && fill_reg == FILL_FULL)
                    begin
                        res_next        = '0;
                        res_next.status = abt_pkg::STATUS_FULL;
                        state_next      = ST_DONE;
                    end
                    else if (req.mode == abt_pkg::MODE_INSERT && req.side[1])
                    begin
                        state_next = ST_INS_NODE;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end

            ST_SCAN:
            begin
                // issue one read per cycle, compare the previous one
                if (match)
                begin
                    hit_next   = rd_idx_reg;
                    state_next = (mode_reg == abt_pkg::MODE_QUERY) ? ST_Q_LINK : ST_INS_NODE;
                end
                else if (scan_reg < fill_reg)
                begin
                    tq.val_raddr = scan_reg[abt_pkg::IDX_W-1:0];
                    rd_idx_next  = scan_reg[abt_pkg::IDX_W-1:0];
                    rd_pend_next = 1'b1;
                    scan_next    = scan_reg + 1'b1;
                end
                else
                begin
                    res_next        = '0;
                    res_next.status = abt_pkg::STATUS_NOT_FOUND;
                    state_next      = ST_DONE;
                end
            end

            ST_INS_NODE:
            begin
                tq.val_we    = 1'b1;
                tq.val_waddr = slot;
                tq.val_wdata = value_reg;
                tq.lft_we    = 1'b1;
                tq.lft_waddr = slot;
                tq.rgt_we    = 1'b1;
                tq.rgt_waddr = slot;
                tq.par_we    = 1'b1;
                tq.par_waddr = slot;
                res_next            = '0;
                res_next.status     = abt_pkg::STATUS_OK;
                res_next.node_index = abt_pkg::out_idx(slot);
                res_next.node_value = value_reg;
                if (side_reg[1])
                begin
                    fill_next  = fill_reg + 1'b1;
                    state_next = ST_DONE;
                end
                else
                begin
                    tq.par_wdata            = '{vld: 1'b1, idx: hit_reg};
                    res_next.parent_present = 1'b1;
                    res_next.parent_index   = abt_pkg::out_idx(hit_reg);
                    state_next              = ST_INS_LINK;
                end
            end

            ST_INS_LINK:
            begin
                // new child replaces any earlier link of the parent
                if (side_reg[0] == abt_pkg::SIDE_LEFT)
                begin
                    tq.lft_we    = 1'b1;
                    tq.lft_waddr = hit_reg;
                    tq.lft_wdata = '{vld: 1'b1, idx: slot};
                end
                else
                begin
                    tq.rgt_we    = 1'b1;
                    tq.rgt_waddr = hit_reg;
                    tq.rgt_wdata = '{vld: 1'b1, idx: slot};
                end
                fill_next  = fill_reg + 1'b1;
                state_next = ST_DONE;
            end

            ST_Q_LINK:
            begin
                tq.lnk_raddr = hit_reg;
                state_next   = ST_Q_LEFT;
            end

            ST_Q_LEFT:
            begin
                par_next     = tr.par_rdata;
                lft_next     = tr.lft_rdata;
                rgt_next     = tr.rgt_rdata;
                tq.val_raddr = tr.lft_rdata.idx;
                state_next   = ST_Q_RIGHT;
            end

            ST_Q_RIGHT:
            begin
                tq.val_raddr = rgt_reg.idx;
                lval_next    = tr.val_rdata;
                state_next   = ST_Q_END;
            end

            ST_Q_END:
            begin
                res_next.status         = abt_pkg::STATUS_OK;
                res_next.node_index     = abt_pkg::out_idx(hit_reg);
                res_next.node_value     = key_reg;
                res_next.parent_present = par_reg.vld;
                res_next.parent_index   = par_reg.vld ? abt_pkg::out_idx(par_reg.idx) : '0;
                res_next.left_present   = lft_reg.vld;
                res_next.left_value     = lft_reg.vld ? lval_reg : 8'd0;
                res_next.right_present  = rgt_reg.vld;
                res_next.right_value    = rgt_reg.vld ? tr.val_rdata : 8'd0;
                state_next              = ST_DONE;
            end

            ST_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mode_reg      <= 1'b0;
            key_reg       <= '0;
            value_reg     <= '0;
            side_reg      <= '0;
            fill_reg      <= '0;
            scan_reg      <= '0;
            rd_pend_reg   <= 1'b0;
            rd_idx_reg    <= '0;
            hit_reg       <= '0;
            par_reg       <= '0;
            lft_reg       <= '0;
            rgt_reg       <= '0;
            lval_reg      <= '0;
            res_reg       <= '0;
            out_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            key_reg       <= key_next;
            value_reg     <= value_next;
            side_reg      <= side_next;
            fill_reg      <= fill_next;
            scan_reg      <= scan_next;
            rd_pend_reg   <= rd_pend_next;
            rd_idx_reg    <= rd_idx_next;
            hit_reg       <= hit_next;
            par_reg       <= par_next;
            lft_reg       <= lft_next;
            rgt_reg       <= rgt_next;
            lval_reg      <= lval_next;
            res_reg       <= res_next;
            out_reg       <= out_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign req.ready          = (state_reg == ST_IDLE);
    assign rsp.valid          = out_valid_reg;
    assign rsp.status         = out_reg.status;
    assign rsp.node_index     = out_reg.node_index;
    assign rsp.node_value     = out_reg.node_value;
    assign rsp.parent_present = out_reg.parent_present;
    assign rsp.parent_index   = out_reg.parent_index;
    assign rsp.left_present   = out_reg.left_present;
    assign rsp.left_value     = out_reg.left_value;
    assign rsp.right_present  = out_reg.right_present;
    assign rsp.right_value    = out_reg.right_value;

    // fill count never runs past the table
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_FULL)
        else $error("fill count beyond table depth");

    // fill count only ever steps up by one
    a_fill_step: assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg != $past(fill_reg)) |-> (fill_reg == $past(fill_reg) + 1'b1))
        else $error("fill count jumped");

    // a pending scan read always points at a used entry
    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN && rd_pend_reg) |-> ({1'b0, rd_idx_reg} < {1'b0, fill_reg}))
        else $error("scan read outside used entries");

    // an error result carries nothing but its status
    a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.status != abt_pkg::STATUS_OK) |->
            (rsp.node_index == '0 && rsp.node_value == '0 && !rsp.parent_present &&
             rsp.parent_index == '0 && !rsp.left_present && rsp.left_value == '0 &&
             !rsp.right_present && rsp.right_value == '0))
        else $error("error result with nonzero fields");

    // a full table never grows
    a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg == FILL_FULL) |=> (fill_reg == FILL_FULL))
        else $error("full table changed");

endmodule
